// File: rtl/core/epll_pkg.sv
`default_nettype none
package epll_pkg;

   // field widths
   localparam int unsigned TIME_W   = 24;
   localparam int unsigned CLOCK_W  = 26;
   localparam int unsigned STEP_W   = 16;
   localparam int unsigned RUN_W    = 4;
   localparam int unsigned STREAK_W = 8;
   localparam int unsigned ERR_W    = 29;
   localparam int unsigned MAG_W    = 28;
   localparam int unsigned PROD_W   = STEP_W + MAG_W;
   localparam int unsigned DIVD_W   = PROD_W + 1;
   localparam int unsigned DIVS_W   = TIME_W + 1;
   localparam int unsigned REM_W    = DIVS_W + 1;
   localparam int unsigned CNT_W    = 6;
   localparam int unsigned RES_W    = 5;
   localparam int unsigned CSR_IDX_W = 8;

   // loop limits
   localparam logic [RUN_W-1:0]   MAX_RUN   = 4'd11;
   localparam logic [RUN_W-1:0]   MIN_RUN   = 4'd3;
   localparam logic [CNT_W-1:0]   TICK_CAP  = 6'd46;
   localparam logic [RES_W-1:0]   RES_CAP   = 5'd16;
   localparam logic [CNT_W-1:0]   DIV_STEPS = 6'd45;
   localparam logic [CLOCK_W-1:0] CT_MAX    = 26'h3FF_FFFF;

   // phase error divisor 40 (20, with error in half-LSB units):
   // add half, shift right by 3 (divide by 8), then multiply by the reciprocal of 5
   localparam logic [ERR_W-1:0]   PHASE_HALF  = 29'd20;
   localparam int unsigned        PHASE_SHIFT = 3;
   localparam int unsigned        RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP5      = 32'hCCCC_CCCD;
   localparam int unsigned        RECIP_SHIFT = 34;
   localparam int unsigned        PH_PROD_W   = DIVS_W + RECIP_W;
   localparam int unsigned        PH_Q_W      = PH_PROD_W - RECIP_SHIFT;

   // register reset values
   localparam logic [TIME_W-1:0] NOMINAL_RST = 24'd606566;
   localparam logic [TIME_W-1:0] MIN_RST     = 24'd454925;
   localparam logic [TIME_W-1:0] MAX_RST     = 24'd758208;
   localparam logic [STEP_W-1:0] STEP_RST    = 16'd61;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOMINAL_PERIOD = 8'd0,
      CSR_MIN_PERIOD     = 8'd1,
      CSR_MAX_PERIOD     = 8'd2,
      CSR_PERIOD_STEP    = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] nominal_period;
      logic [TIME_W-1:0] min_period;
      logic [TIME_W-1:0] max_period;
      logic [STEP_W-1:0] period_step;
      logic              nominal_load;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/epll_fifo.sv
`default_nettype none
module epll_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // advance pointers with wrap and update the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/epll_div.sv
`default_nettype none
module epll_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire epll_pkg::div_req_type req,
   output epll_pkg::div_rsp_type      rsp
);
   import epll_pkg::*;

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] divisor_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic              fits;

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   always_comb begin
      rem_sh  = {rem_ff[REM_W-2:0], quo_ff[DIVD_W-1]};
      fits    = (rem_sh >= {1'b0, divisor_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, divisor_ff} : rem_sh;
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (req.start) begin
         divisor_ff <= req.divisor;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/epll_engine.sv
`default_nettype none
module epll_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire epll_pkg::cfg_type                   cfg,
   input  wire logic                                in_valid,
   input  wire logic [epll_pkg::TIME_W-1:0]         in_data,
   output logic                                     in_pop,
   input  wire logic                                out_full,
   output logic                                     out_push,
   output logic [epll_pkg::RUN_W:0]                 out_data,
   output epll_pkg::div_req_type                    div_req,
   input  wire epll_pkg::div_rsp_type               div_rsp
);
   import epll_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_CHECK  = 11'b000_0000_0010,
      ST_TICK   = 11'b000_0000_0100,
      ST_DECIDE = 11'b000_0000_1000,
      ST_PSTART = 11'b000_0001_0000,
      ST_PDIV   = 11'b000_0010_0000,
      ST_MUL    = 11'b000_0100_0000,
      ST_FSTART = 11'b000_1000_0000,
      ST_FDIV   = 11'b001_0000_0000,
      ST_EMIT   = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   state_type                  state_ff, state_in;
   logic [TIME_W-1:0]          sd_ff, sd_in;
   logic [CLOCK_W-1:0]         ct_ff, ct_in;
   logic [TIME_W-1:0]          pnow_ff, pnow_in;
   logic signed [TIME_W-1:0]   pc_ff, pc_in;
   logic signed [STREAK_W-1:0] streak_ff, streak_in;
   logic [RUN_W-1:0]           rc_ff, rc_in;
   logic [CNT_W-1:0]           ticks_ff, ticks_in;
   logic [RES_W-1:0]           nres_ff, nres_in;
   logic signed [ERR_W-1:0]    d2_ff, d2_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [PH_PROD_W-1:0]       ph_prod_ff, ph_prod_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [RUN_W-1:0]           pend_run_ff, pend_run_in;

   logic signed [CLOCK_W-1:0]  adv_s;
   logic [DIVS_W-1:0]          adv;
   logic [CLOCK_W:0]           next_sum;
   logic signed [ERR_W-1:0]    d2_now;
   logic [ERR_W-1:0]           d2_abs;
   logic [MAG_W-1:0]           d2_mag;
   logic                       d2_neg;
   logic                       extend;
   logic signed [DIVD_W:0]     p_new;
   logic [DIVS_W-1:0]          ph_x;
   logic [PH_Q_W-1:0]          ph_q;

   // bound the period: lower clamp first, then upper clamp
   function automatic logic [TIME_W-1:0] clamp_period(
      input logic signed [DIVD_W:0] p,
      input logic [TIME_W-1:0]      lo,
      input logic [TIME_W-1:0]      hi
   );
      logic [TIME_W-1:0] r;
      if (p < $signed({{(DIVD_W - TIME_W + 1){1'b0}}, lo})) begin
         r = lo;
      end else if (p > $signed({{(DIVD_W - TIME_W + 1){1'b0}}, hi})) begin
         r = hi;
      end else begin
         r = p[TIME_W-1:0];
      end
      return r;
   endfunction

   assign d2_neg = d2_ff[ERR_W-1];
   assign d2_abs = d2_neg ? ERR_W'(-d2_ff) : ERR_W'(d2_ff);
   assign d2_mag = d2_abs[MAG_W-1:0];
   // rounded error magnitude over 8; the reciprocal product then divides by 5
   assign ph_x   = DIVS_W'((d2_abs + PHASE_HALF) >> PHASE_SHIFT);
   assign ph_q   = ph_prod_ff[PH_PROD_W-1:RECIP_SHIFT];

   always_comb begin
      // tick advance, at least one LSB, saturating tick time
      adv_s    = $signed({2'b00, pnow_ff}) + $signed({{2{pc_ff[TIME_W-1]}}, pc_ff});
      adv      = (adv_s < 26'sd1) ? DIVS_W'(1) : adv_s[DIVS_W-1:0];
      next_sum = {1'b0, ct_ff} + {2'b00, adv};
      // error in half LSBs against the current tick time
      d2_now   = $signed({4'b0, sd_ff, 1'b0}) - $signed({2'b0, ct_ff, 1'b0})
               + $signed({5'b0, pnow_ff});
      extend   = (({2'b00, sd_ff} > ct_ff) || rc_ff < MIN_RUN)
                 && !(rc_ff > MAX_RUN - 1'b1);
      p_new    = $signed({{(DIVD_W - TIME_W + 1){1'b0}}, pnow_ff})
               + (d2_neg ? -$signed({1'b0, div_rsp.quotient})
                         : $signed({1'b0, div_rsp.quotient}));
   end

   always_comb begin
      state_in      = state_ff;
      sd_in         = sd_ff;
      ct_in         = ct_ff;
      pnow_in       = pnow_ff;
      pc_in         = pc_ff;
      streak_in     = streak_ff;
      rc_in         = rc_ff;
      ticks_in      = ticks_ff;
      nres_in       = nres_ff;
      d2_in         = d2_ff;
      prod_in       = prod_ff;
      ph_prod_in    = ph_prod_ff;
      pend_valid_in = pend_valid_ff;
      pend_run_in   = pend_run_ff;
      in_pop        = 1'b0;
      out_push      = 1'b0;
      out_data      = {1'b0, pend_run_ff};
      div_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               in_pop   = 1'b1;
               sd_in    = in_data;
               ticks_in = '0;
               nres_in  = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ({2'b00, sd_ff} >= ct_ff && ticks_ff < TICK_CAP && nres_ff < RES_CAP) begin
               state_in = ST_TICK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_TICK: begin
            ct_in    = (next_sum > {1'b0, CT_MAX}) ? CT_MAX : next_sum[CLOCK_W-1:0];
            ticks_in = ticks_ff + 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (extend) begin
               pc_in    = '0;
               rc_in    = rc_ff + 1'b1;
               state_in = ST_CHECK;
            end else begin
               d2_in = d2_now;
               // track same-sign error streak, saturating
               if (d2_now < 0) begin
                  if (streak_ff < 0) begin
                     if (streak_ff > -8'sd128) streak_in = streak_ff - 1'b1;
                  end else begin
                     streak_in = -8'sd1;
                  end
               end else if (d2_now > 0) begin
                  if (streak_ff > 0) begin
                     if (streak_ff < 8'sd127) streak_in = streak_ff + 1'b1;
                  end else begin
                     streak_in = 8'sd1;
                  end
               end else begin
                  streak_in = '0;
               end
               state_in = ST_PSTART;
            end
         end
         ST_PSTART: begin
            // scale the rounded error by the reciprocal of 5
            ph_prod_in = {{RECIP_W{1'b0}}, ph_x} * {{DIVS_W{1'b0}}, RECIP5};
            state_in   = ST_PDIV;
         end
         ST_PDIV: begin
            // phase correction; its magnitude stays below 2^23, inside signed 24 bits
            pc_in    = d2_neg ? -$signed({1'b0, ph_q}) : $signed({1'b0, ph_q});
            state_in = (streak_ff > 8'sd1 || streak_ff < -8'sd1) ? ST_MUL : ST_EMIT;
         end
         ST_MUL: begin
            prod_in = {{MAG_W{1'b0}}, cfg.period_step} * {{STEP_W{1'b0}}, d2_mag};
            if (pnow_ff == '0) begin
               pnow_in  = clamp_period('0, cfg.min_period, cfg.max_period);
               state_in = ST_EMIT;
            end else begin
               state_in = ST_FSTART;
            end
         end
         ST_FSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, prod_ff} + {{(DIVD_W - TIME_W){1'b0}}, pnow_ff};
            div_req.divisor  = {pnow_ff, 1'b0};
            state_in         = ST_FDIV;
         end
         ST_FDIV: begin
            if (div_rsp.done) begin
               pnow_in  = clamp_period(p_new, cfg.min_period, cfg.max_period);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // release the held run, hold the new one until its last flag is known
            if (!(pend_valid_ff && out_full)) begin
               out_push      = pend_valid_ff;
               pend_run_in   = rc_ff;
               pend_valid_in = 1'b1;
               rc_in         = 4'd1;
               nres_in       = nres_ff + 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!(pend_valid_ff && out_full)) begin
               out_push      = pend_valid_ff;
               out_data      = {1'b1, pend_run_ff};
               pend_valid_in = 1'b0;
               ct_in         = (ct_ff > {2'b00, sd_ff}) ? ct_ff - {2'b00, sd_ff} : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // nominal period write reloads the running period
      if (cfg.nominal_load) begin
         pnow_in = cfg.nominal_period;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ct_ff         <= '0;
         pnow_ff       <= NOMINAL_RST;
         pc_ff         <= '0;
         streak_ff     <= '0;
         rc_ff         <= 4'd1;
         ticks_ff      <= '0;
         nres_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ct_ff         <= ct_in;
         pnow_ff       <= pnow_in;
         pc_ff         <= pc_in;
         streak_ff     <= streak_in;
         rc_ff         <= rc_in;
         ticks_ff      <= ticks_in;
         nres_ff       <= nres_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sd_ff       <= sd_in;
      d2_ff       <= d2_in;
      prod_ff     <= prod_in;
      ph_prod_ff  <= ph_prod_in;
      pend_run_ff <= pend_run_in;
   end

endmodule
`default_nettype wire

// File: rtl/core/efm_bit_clock_recovery_pll_unit.sv
`default_nettype none
// EFM bit clock recovery loop. Each pushed item is the interval between two zero
// crossings (unsigned Q8.16 samples); the block steps a recovered bit clock across
// it and pops out the completed run lengths (3 to 11), the last one of each edge
// marked with rsp_last. An edge may yield no run at all. Intervals wait in a
// two-entry input queue and runs in a four-entry output queue. Per edge the loop
// steps through its ticks; a tick that closes a run also runs the phase correction
// (a reciprocal multiply), and a period retune uses the restoring divider, which
// retires one quotient bit per cycle (45 bits). A full output queue stalls the
// loop. Registers: 0 nominal period (a write also reloads the running period),
// 1 minimum period, 2 maximum period, 3 period step. Write them only while the
// block is idle; csr_ready is always high.
module efm_bit_clock_recovery_pll_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [epll_pkg::TIME_W-1:0]      req_edge_interval,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic [epll_pkg::RUN_W-1:0]            rsp_run_length,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [epll_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [epll_pkg::TIME_W-1:0]      csr_data
);
   import epll_pkg::*;

   localparam int unsigned REQ_DEPTH = 2;
   localparam int unsigned RSP_DEPTH = 4;

   logic [TIME_W-1:0] nominal_ff, nominal_in, min_ff, min_in, max_ff, max_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              csr_xfer;
   cfg_type           cfg;
   logic              eng_in_valid, eng_in_pop, req_empty;
   logic [TIME_W-1:0] eng_in_data;
   logic              eng_out_full, eng_out_push;
   logic [RUN_W:0]    eng_out_data, rsp_data;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   // register file writes
   always_comb begin
      nominal_in = nominal_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      step_in    = step_ff;
      if (csr_xfer) begin
         case (csr_index)
            CSR_NOMINAL_PERIOD: nominal_in = csr_data;
            CSR_MIN_PERIOD:     min_in     = csr_data;
            CSR_MAX_PERIOD:     max_in     = csr_data;
            CSR_PERIOD_STEP:    step_in    = csr_data[STEP_W-1:0];
            default:            nominal_in = nominal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff <= NOMINAL_RST;
         min_ff     <= MIN_RST;
         max_ff     <= MAX_RST;
         step_ff    <= STEP_RST;
      end else begin
         nominal_ff <= nominal_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         step_ff    <= step_in;
      end
   end

   assign cfg.nominal_period = nominal_in;
   assign cfg.min_period     = min_ff;
   assign cfg.max_period     = max_ff;
   assign cfg.period_step    = step_ff;
   assign cfg.nominal_load   = csr_xfer && (csr_index == CSR_NOMINAL_PERIOD);

   // front: edge interval queue
   epll_fifo #(.WIDTH(TIME_W), .DEPTH(REQ_DEPTH)) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_edge_interval),
      .full      (req_full),
      .pop       (eng_in_pop),
      .pop_data  (eng_in_data),
      .empty     (req_empty)
   );
   assign eng_in_valid = !req_empty;

   // back: tick loop
   epll_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (eng_in_valid),
      .in_data  (eng_in_data),
      .in_pop   (eng_in_pop),
      .out_full (eng_out_full),
      .out_push (eng_out_push),
      .out_data (eng_out_data),
      .div_req  (div_req),
      .div_rsp  (div_rsp)
   );

   epll_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // run length queue
   epll_fifo #(.WIDTH(RUN_W + 1), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_out_push),
      .push_data (eng_out_data),
      .full      (eng_out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_run_length = rsp_data[RUN_W-1:0];
   assign rsp_last       = rsp_data[RUN_W];

endmodule
`default_nettype wire

// File: rtl/core/epll_checker.sv
`default_nettype none
module epll_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic [epll_pkg::RUN_W-1:0]     rsp_run_length,
   input wire logic                           rsp_last,
   input wire logic                           csr_ready
);
   import epll_pkg::*;

   // every delivered run lies in the legal span
   a_run_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_run_length >= MIN_RUN && rsp_run_length <= MAX_RUN))
      else $error("run length out of range");

   // reset drains the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("results visible after reset");

   // register port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr_ready dropped");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_run_length) && $stable(rsp_last)))
      else $error("waiting result changed");

endmodule

bind efm_bit_clock_recovery_pll_unit epll_checker u_epll_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_run_length (rsp_run_length),
   .rsp_last       (rsp_last),
   .csr_ready      (csr_ready)
);
`default_nettype wire
